// ----- rtl/core/mhpq_pkg.sv -----
// Package: word types, operation codes and constants of the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic signed [31:0] EMPTY_CODE = -32'sd1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic               was_empty;
    logic               was_full;
    logic [7:0]         entry_total;
  } out_word_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic               ins;
    logic               ext;
    logic signed [31:0] value;
  } mhpq_ctl_t;

endpackage : mhpq_pkg

`default_nettype wire

// ----- rtl/core/mhpq_cell.sv -----
// Cell: one slot of the sorted row; shifts right on insert, left on extract.
`default_nettype none

module mhpq_cell (
  input  wire logic               clk,
  input  wire mhpq_pkg::mhpq_ctl_t ctl,
  input  wire logic               occ,
  input  wire logic signed [31:0] left_val,
  input  wire logic               left_gt,
  input  wire logic signed [31:0] right_val,
  output logic signed [31:0]      val,
  output logic                    gt
);
  import mhpq_pkg::*;

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // new value outranks this slot (an empty slot ranks lowest)
  assign gt  = !occ || (ctl.value > val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt) begin
        val_nxt = ctl.value;
      end
    end else if (ctl.ext) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule : mhpq_cell

`default_nettype wire

// ----- rtl/core/max_heap_priority_queue_top.sv -----
// Top level: max priority queue built as a sorted chain of cells.
//
//   channel | ports                      | direction | word
//   --------+----------------------------+-----------+----------------
//   in      | in_valid, in_stall, in_word | sink      | in_word_t
//   out     | out_valid, out_stall, out_word | source | out_word_t
//
// One word per cycle while in_stall is low: every cell compares the new value
// with its own entry in parallel and takes its neighbor's entry in the same
// cycle, so an item is done at the edge that accepts it, and its result word
// is registered into out_word at that same edge.
// Synchronous active-low reset empties the queue (fill count to zero) and
// clears out_valid; no clearing pass. in_stall is high only while a result
// waits in the output register and out_stall holds it.
`default_nettype none

module max_heap_priority_queue_top #(
  parameter int HEAP_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mhpq_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mhpq_pkg::out_word_t      out_word
);
  import mhpq_pkg::*;

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HEAP_DEPTH);

  // fill count: cells below it hold entries, sorted largest first
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;
  out_word_t out_word_nxt;

  logic      accept;
  logic      is_full;
  logic      is_empty;
  mhpq_ctl_t ctl;

  logic signed [31:0] cell_val [HEAP_DEPTH];
  logic               cell_gt  [HEAP_DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  assign ctl.ins   = accept && (in_word.operation == OP_INSERT) && !is_full;
  assign ctl.ext   = accept && (in_word.operation == OP_EXTRACT) && !is_empty;
  assign ctl.value = in_word.new_value;

  // the row of cells; cell 0 holds the maximum
  for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_cell
    logic signed [31:0] left_val;
    logic               left_gt;
    logic signed [31:0] right_val;

    if (g == 0) begin : g_head
      assign left_val = ctl.value;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[g-1];
      assign left_gt  = cell_gt[g-1];
    end

    if (g == HEAP_DEPTH - 1) begin : g_tail
      // last slot empties on extract; its content is don't-care
      assign right_val = cell_val[g];
    end else begin : g_body
      assign right_val = cell_val[g+1];
    end

    mhpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (count_r > CNT_W'(g)),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (cell_val[g]),
      .gt        (cell_gt[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.ext) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_word_nxt.max_value   = '0;
    out_word_nxt.was_empty   = 1'b0;
    out_word_nxt.was_full    = 1'b0;
    out_word_nxt.entry_total = 8'(count_nxt);
    if (in_word.operation == OP_EXTRACT) begin
      if (is_empty) begin
        out_word_nxt.max_value = EMPTY_CODE;
        out_word_nxt.was_empty = 1'b1;
      end else begin
        out_word_nxt.max_value = cell_val[0];
      end
    end else begin
      out_word_nxt.was_full = is_full;
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule : max_heap_priority_queue_top

`default_nettype wire

// ----- rtl/core/mhpq_checker.sv -----
// Checker: port-level assertions for the max priority queue, bound to the top level.
`default_nettype none

module mhpq_checker #(
  parameter int HEAP_DEPTH = 128
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mhpq_pkg::out_word_t out_word
);
  import mhpq_pkg::*;

  localparam logic [7:0] FULL_TOTAL = 8'(HEAP_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.was_empty |->
      out_word.max_value == EMPTY_CODE && out_word.entry_total == 8'd0)
    else $error("empty extract must return -1 with zero entries");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.was_empty && out_word.was_full))
    else $error("empty and full flags both set");

  a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.was_full |->
      out_word.entry_total == FULL_TOTAL && out_word.max_value == 32'sd0)
    else $error("dropped insert must report a full queue");

  a_accept_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

endmodule : mhpq_checker

bind max_heap_priority_queue_top mhpq_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_mhpq_checker (.*);

`default_nettype wire

// ----- dv/mhpq_heap_check.sv -----
// Monitor that predicts the max-heap queue from accepted input words and checks each result word.
`default_nettype none

module mhpq_heap_check #(
  parameter int HEAP_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire mhpq_pkg::in_word_t  in_word,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire mhpq_pkg::out_word_t out_word,
  output int                       mismatch_total,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] heap_mem [HEAP_DEPTH];
  int unsigned        fill_level;
  out_word_t          pending_results [$];
  int                 mismatches;

  // Apply one operation to the private heap and return the result word it should produce.
  function automatic out_word_t heap_apply(input in_word_t w);
    out_word_t          r;
    int unsigned        pos;
    int unsigned        up;
    int unsigned        lc;
    int unsigned        rc;
    int unsigned        best;
    logic signed [31:0] tmp;
    logic               moving;
    r = '0;
    if (w.operation == OP_INSERT) begin
      if (fill_level >= HEAP_DEPTH) begin
        r.was_full = 1'b1;
      end else begin
        pos = fill_level;
        heap_mem[pos] = w.new_value;
        fill_level++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_mem[pos] > heap_mem[up]) begin
            tmp = heap_mem[pos];
            heap_mem[pos] = heap_mem[up];
            heap_mem[up] = tmp;
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else if (fill_level == 0) begin
      r.max_value = EMPTY_CODE;
      r.was_empty = 1'b1;
    end else begin
      r.max_value = heap_mem[0];
      heap_mem[0] = heap_mem[fill_level - 1];
      fill_level--;
      pos = 0;
      moving = 1'b1;
      while (moving) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        best = pos;
        // left child wins a tie between equal children
        if (lc < fill_level && heap_mem[lc] > heap_mem[best]) best = lc;
        if (rc < fill_level && heap_mem[rc] > heap_mem[best]) best = rc;
        if (best == pos) begin
          moving = 1'b0;
        end else begin
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[best];
          heap_mem[best] = tmp;
          pos = best;
        end
      end
    end
    r.entry_total = fill_level[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      fill_level = 0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      // result side first: a word accepted at this edge cannot answer one accepted here too
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected result word: max %0d empty %0b full %0b total %0d",
                     $realtime, out_word.max_value, out_word.was_empty, out_word.was_full,
                     out_word.entry_total);
        end else begin
          want = pending_results.pop_front();
          if (out_word.max_value !== want.max_value || out_word.was_empty !== want.was_empty ||
              out_word.was_full !== want.was_full ||
              out_word.entry_total !== want.entry_total) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"[%0t] result mismatch: exp max %0d empty %0b full %0b total %0d,",
                        " got max %0d empty %0b full %0b total %0d"}, $realtime,
                       want.max_value, want.was_empty, want.was_full, want.entry_total,
                       out_word.max_value, out_word.was_empty, out_word.was_full,
                       out_word.entry_total);
          end
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(heap_apply(in_word));
    end
    outstanding    <= pending_results.size();
    mismatch_total <= mismatches;
  end

endmodule : mhpq_heap_check

`default_nettype wire

// ----- dv/tb_max_heap_priority_queue_top.sv -----
// Testbench top: clock, reset, stimulus and receiver stalls for the max-heap queue, plus verdict.
`default_nettype none

module tb_max_heap_priority_queue_top;
  import mhpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  QUEUE_DEPTH    = 128;
  localparam real CLK_PERIOD     = 12.0;
  localparam int  RESET_CYCLES   = 7;
  localparam int  ITEM_GOAL      = 700;
  // no sender gaps and no receiver stalls over the last stretch of words
  localparam int  CALM_TAIL      = 80;
  // receiver blocks once for this long so the queue backs up into in_stall
  localparam int  LONG_HOLD      = 300;
  localparam int  LONG_HOLD_AT   = 250;
  // a few extra edges after the drain catch any stray result word
  localparam int  DRAIN_PAD      = 8;
  // worst quiet stretch in a correct run is the long hold; take it several times over
  localparam int  WATCHDOG_LIMIT = 2000;

  typedef enum int {EP_MIXED, EP_FILL, EP_DRAIN, EP_TIES} episode_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int        mismatch_total;
  int        outstanding;

  // stimulus bookkeeping: entry count the queue will hold once every sent word lands
  int        queue_level;
  int        sent_total;
  int        gap_pct;
  logic      calm;
  logic      held_long;
  int        idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  max_heap_priority_queue_top #(
    .HEAP_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  mhpq_heap_check #(
    .HEAP_DEPTH(QUEUE_DEPTH)
  ) heap_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .mismatch_total(mismatch_total),
    .outstanding   (outstanding)
  );

  // Value mix: a third full-range random, with extremes, clustered ties and values
  // hugging either end of the signed range so comparisons across the sign bit get hit.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $signed($urandom_range(0, 8)) - 32'sd4;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      2: v = 32'sh7FFFFFF0 | $urandom_range(0, 15);
      3: v = 32'sh80000000 | $urandom_range(0, 15);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one word and hold it until the queue takes it. A random gap may come first,
  // with valid low; valid otherwise stays high from one word into the next.
  task automatic issue(input logic op, input logic signed [31:0] v);
    in_word_t w;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    w.operation = op;
    w.new_value = v;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    if (op == OP_INSERT) begin
      if (queue_level < QUEUE_DEPTH) queue_level++;
    end else if (queue_level > 0) begin
      queue_level--;
    end
    if (sent_total >= ITEM_GOAL - CALM_TAIL) calm = 1'b1;
  endtask

  // Receiver: random stall bursts between open runs, one long hold partway through,
  // and no stalls at all once the calm tail starts.
  initial begin
    int hold_cycles;
    out_stall = 1'b0;
    held_long = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_long && sent_total >= LONG_HOLD_AT) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Watchdog: cycles with no word accepted on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    episode_t episode;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    idle_cycles = 0;
    queue_level = 0;
    sent_total  = 0;
    calm        = 1'b0;
    gap_pct     = 30;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extract from an empty queue (value field set, must be ignored)
    issue(OP_EXTRACT, 32'sh7FFFFFFF);
    // both signed extremes, zero, -1, 1 and duplicates, then drain in order
    issue(OP_INSERT, 32'sh7FFFFFFF);
    issue(OP_INSERT, 32'sh80000000);
    issue(OP_INSERT, 32'sd0);
    issue(OP_INSERT, -32'sd1);
    issue(OP_INSERT, 32'sd1);
    issue(OP_INSERT, 32'sd5);
    issue(OP_INSERT, 32'sd5);
    issue(OP_INSERT, -32'sd1);
    repeat (8) issue(OP_EXTRACT, $urandom);
    // drained: empty again
    issue(OP_EXTRACT, 32'sh80000000);
    // the only entry goes out and the queue empties
    issue(OP_INSERT, 32'sd42);
    issue(OP_EXTRACT, 32'sd0);
    issue(OP_EXTRACT, -32'sd1);

    // Random episodes. The first one fills the queue to the top so a dropped insert
    // is always seen; drains run to empty and past it. Ties use a narrow value band.
    episode = EP_FILL;
    while (sent_total < ITEM_GOAL) begin
      gap_pct = 20 * $urandom_range(0, 2);
      case (episode)
        EP_FILL: begin
          while (queue_level < QUEUE_DEPTH)
            issue(($urandom_range(0, 9) == 0) ? OP_EXTRACT : OP_INSERT, pick_value());
          repeat ($urandom_range(1, 4)) issue(OP_INSERT, pick_value());
        end
        EP_DRAIN: begin
          while (queue_level > 0)
            issue(($urandom_range(0, 9) == 0) ? OP_INSERT : OP_EXTRACT, pick_value());
          repeat ($urandom_range(1, 3)) issue(OP_EXTRACT, $urandom);
        end
        EP_TIES: begin
          repeat (30)
            issue($urandom_range(0, 1) ? OP_EXTRACT : OP_INSERT,
                  $signed($urandom_range(0, 6)) - 32'sd3);
        end
        default: begin
          repeat (40) issue($urandom_range(0, 1) ? OP_EXTRACT : OP_INSERT, pick_value());
        end
      endcase
      episode = episode_t'($urandom_range(0, 3));
    end

    // All words sent: let the last result arrive, then give the queue a few more edges.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    if (mismatch_total == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : tb_max_heap_priority_queue_top

`default_nettype wire
